// ----- rtl/lrt_pkg.sv -----
// Shared constants and types for the line region translation table.
package lrt_pkg;

   localparam int LINE_W                = 24;
   localparam int FILE_W                = 8;
   localparam int STATUS_W              = 2;
   localparam int DEFAULT_TABLE_ENTRIES = 64;

   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ORDER     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

   typedef struct packed {
      logic [FILE_W-1:0] file;
      logic [LINE_W-1:0] target;
      logic [LINE_W-1:0] start;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FILE_W-1:0]   mapped_file;
      logic [LINE_W-1:0]   mapped_line;
   } result_type;

endpackage

// ----- rtl/line_region_translate_table.sv -----
// Top level of the line region translation table with stream ports and result register.
//
//  Channel  Direction  Carries
//  req_     in         tuser: opcode; tdata: source_line, target_line, file_number
//  rsp_     out        tdata: status, mapped_file, mapped_line
//
// An append result is registered in the core and then in the output register before it reaches rsp_tvalid.
// A lookup runs a binary search over the filled entries, in which each step reads the table
// memory and compares in the following cycle.
// Reset leaves one entry, line 0 to line 0 of file 0; no clearing pass is needed.
// A result waits in the output register while the next item is taken and worked on.
module line_region_translate_table
   import lrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // source_line[23:0], target_line[47:24], file_number[55:48]
   input  logic        req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], mapped_file[9:2], mapped_line[33:10], zero
);

   logic       core_idle;
   logic       done_valid;
   logic       done_take;
   result_type done_result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   lrt_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid & req_tready),
      .opcode     (req_tuser),
      .source_line(req_tdata[23:0]),
      .target_line(req_tdata[47:24]),
      .file_number(req_tdata[55:48]),
      .idle       (core_idle),
      .done_valid (done_valid),
      .done_take  (done_take),
      .done_result(done_result)
   );

   assign req_tready = core_idle;
   assign done_take  = done_valid & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) begin
         rsp_data_ff <= done_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.mapped_line, rsp_data_ff.mapped_file,
                        rsp_data_ff.status};

endmodule

// ----- rtl/lrt_core.sv -----
// Region table memory with append logic and a binary search sequencer for lookups.
module lrt_core
   import lrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              opcode,
   input  logic [LINE_W-1:0] source_line,
   input  logic [LINE_W-1:0] target_line,
   input  logic [FILE_W-1:0] file_number,
   output logic              idle,
   output logic              done_valid,
   input  logic              done_take,
   output result_type        done_result
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_CMP    = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   entry_type table_mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LINE_W-1:0] last_start_ff, last_start_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [LINE_W-1:0] line_ff, line_in;
   entry_type         lo_entry_ff, lo_entry_in;
   result_type        res_ff, res_in;

   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  mid;
   logic [LINE_W-1:0] offset;
   logic [LINE_W:0]   sum;
   logic              wr_en;
   logic              rd_en;
   entry_type         wr_entry;

   assign span   = hi_ff - lo_ff;
   assign mid    = lo_ff + (span >> 1);
   assign offset = line_ff - lo_entry_ff.start;
   assign sum    = {1'b0, lo_entry_ff.target} + {1'b0, offset};

   assign wr_entry = '{file: file_number, target: target_line, start: source_line};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_start_in = last_start_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      line_in       = line_ff;
      lo_entry_in   = lo_entry_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (opcode == OP_APPEND) begin
                  res_in   = '0;
                  state_in = S_DONE;
                  if (source_line <= last_start_ff) begin
                     res_in.status = ST_ORDER;
                  end else if (count_ff == CNT_FULL) begin
                     res_in.status = ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_ONE;
                     last_start_in = source_line;
                  end
               end else begin
                  line_in     = source_line;
                  lo_in       = '0;
                  hi_in       = count_ff;
                  lo_entry_in = '0;
                  state_in    = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (span > CNT_ONE) begin
               rd_en    = 1'b1;
               state_in = S_CMP;
            end else begin
               res_in.mapped_file = lo_entry_ff.file;
               if (sum[LINE_W]) begin
                  res_in.status      = ST_SATURATED;
                  res_in.mapped_line = LINE_MAX;
               end else begin
                  res_in.status      = ST_OK;
                  res_in.mapped_line = sum[LINE_W-1:0];
               end
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            if (rd_data_ff.start <= line_ff) begin
               lo_in       = mid;
               lo_entry_in = rd_data_ff;
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end
         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[mid[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= CNT_ONE;
         last_start_ff <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_start_ff <= last_start_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      line_ff     <= line_in;
      lo_entry_ff <= lo_entry_in;
      res_ff      <= res_in;
   end

   assign idle        = (state_ff == S_IDLE);
   assign done_valid  = (state_ff == S_DONE);
   assign done_result = res_ff;

endmodule

// ----- tb/tb_line_region_translate_table.sv -----
// Self-checking testbench for the line region translation table: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb_line_region_translate_table;
   import lrt_pkg::*;

   localparam int TABLE_ENTRIES = 64;
   localparam int ITEM_TOTAL    = 850;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DIR_ROWS      = 20;
   localparam int MAX_STEP      = 140000;

   typedef struct packed {
      logic              op;
      logic [LINE_W-1:0] src;
      logic [LINE_W-1:0] tgt;
      logic [FILE_W-1:0] file;
      logic              typed;
      result_type        res;
   } dir_row_type;

   localparam result_type NO_RES       = '0;
   localparam result_type APPEND_OK    = '{ST_OK, 8'h00, 24'h000000};
   localparam result_type APPEND_ORDER = '{ST_ORDER, 8'h00, 24'h000000};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // source_line[23:0], target_line[47:24], file_number[55:48]
   logic        req_tuser = 1'b0; // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // status[1:0], mapped_file[9:2], mapped_line[33:10], zero

   logic [LINE_W-1:0] tbl_start  [TABLE_ENTRIES];
   logic [LINE_W-1:0] tbl_target [TABLE_ENTRIES];
   logic [FILE_W-1:0] tbl_file   [TABLE_ENTRIES];
   int                tbl_count;

   result_type expected_results[$];
   int         mismatches = 0;
   int         items_sent = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;
   logic       calm = 1'b0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{OP_LOOKUP, 24'h000000, 24'h000000, 8'h00, 1'b1, '{ST_OK, 8'h00, 24'h000000}},
      '{OP_LOOKUP, 24'hFFFFFF, 24'h000000, 8'h00, 1'b1, '{ST_OK, 8'h00, 24'hFFFFFF}},
      '{OP_APPEND, 24'h000000, 24'h00007B, 8'h07, 1'b1, APPEND_ORDER},
      '{OP_APPEND, 24'h00000A, 24'hFFFFFF, 8'hFF, 1'b1, APPEND_OK},
      '{OP_LOOKUP, 24'h000009, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'h00000A, 24'h000000, 8'h00, 1'b1, '{ST_OK, 8'hFF, 24'hFFFFFF}},
      '{OP_LOOKUP, 24'h00000B, 24'h000000, 8'h00, 1'b1, '{ST_SATURATED, 8'hFF, 24'hFFFFFF}},
      '{OP_APPEND, 24'h00000A, 24'h000000, 8'h01, 1'b1, APPEND_ORDER},
      '{OP_APPEND, 24'h000005, 24'h000000, 8'h01, 1'b1, APPEND_ORDER},
      '{OP_APPEND, 24'h000014, 24'h000000, 8'h5A, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'h000013, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'h000014, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'hFFFFFF, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_APPEND, 24'h000015, 24'h800000, 8'hA5, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'h000015, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'hFFFFFF, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_APPEND, 24'h7FFFFF, 24'h000000, 8'h3C, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'h7FFFFE, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_LOOKUP, 24'hFFFFFF, 24'h000000, 8'h00, 1'b0, NO_RES},
      '{OP_APPEND, 24'h7FFFFF, 24'h000000, 8'h00, 1'b1, APPEND_ORDER}
   };

   line_region_translate_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic result_type translate_or_append(input logic op,
                                                      input logic [LINE_W-1:0] src,
                                                      input logic [LINE_W-1:0] tgt,
                                                      input logic [FILE_W-1:0] file);
      result_type        r;
      int                hit;
      logic [LINE_W:0]   sum;
      r = '0;
      if (op == OP_APPEND) begin
         if (src <= tbl_start[tbl_count-1]) begin
            r.status = ST_ORDER;
         end else if (tbl_count >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
         end else begin
            tbl_start[tbl_count]  = src;
            tbl_target[tbl_count] = tgt;
            tbl_file[tbl_count]   = file;
            tbl_count++;
         end
      end else begin
         hit = 0;
         for (int i = 1; i < tbl_count; i++) begin
            if (tbl_start[i] <= src) hit = i;
         end
         sum = {1'b0, tbl_target[hit]} + {1'b0, src - tbl_start[hit]};
         r.mapped_file = tbl_file[hit];
         if (sum > {1'b0, LINE_MAX}) begin
            r.mapped_line = LINE_MAX;
            r.status      = ST_SATURATED;
         end else begin
            r.mapped_line = sum[LINE_W-1:0];
            r.status      = ST_OK;
         end
      end
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [LINE_W-1:0] pick_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return LINE_MAX - LINE_W'($urandom_range(0, 1000));
      if (r < 18) return '0;
      return LINE_W'($urandom);
   endfunction

   function automatic logic [LINE_W-1:0] pick_lookup_line();
      int                r;
      int                k;
      logic [LINE_W-1:0] last;
      r    = $urandom_range(0, 99);
      k    = $urandom_range(0, tbl_count - 1);
      last = tbl_start[tbl_count-1];
      if (r < 45) return tbl_start[k] + LINE_W'($urandom_range(0, 2));
      if (r < 60) return (tbl_start[k] == 0) ? '0 : tbl_start[k] - 1'b1;
      if (r < 80) return LINE_W'($urandom);
      if (r < 85) return LINE_MAX;
      return LINE_W'($urandom_range(last, LINE_MAX));
   endfunction

   function automatic logic [LINE_W-1:0] pick_ordered_start();
      logic [LINE_W-1:0] last;
      int                room;
      last = tbl_start[tbl_count-1];
      room = int'(LINE_MAX - last);
      if (room == 0) return last;
      return last + LINE_W'($urandom_range(1, (room < MAX_STEP) ? room : MAX_STEP));
   endfunction

   function automatic logic [LINE_W-1:0] pick_stale_start();
      logic [LINE_W-1:0] last;
      last = tbl_start[tbl_count-1];
      if ($urandom_range(0, 2) == 0) return last;
      return LINE_W'($urandom_range(0, last));
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic send_item(input logic op, input logic [LINE_W-1:0] src,
                            input logic [LINE_W-1:0] tgt, input logic [FILE_W-1:0] file,
                            input logic typed, input result_type typed_res);
      int         gap;
      result_type predicted;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {file, tgt, src};
      do @(posedge clock); while (!req_tready);
      predicted = translate_or_append(op, src, tgt, file);
      expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
      items_sent++;
      if (items_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int append_pct);
      logic [LINE_W-1:0] src;
      if ($urandom_range(0, 99) < append_pct) begin
         if ($urandom_range(0, 99) < 80) begin
            src = (tbl_count >= TABLE_ENTRIES && $urandom_range(0, 7) == 0) ?
                  LINE_MAX : pick_ordered_start();
         end else begin
            src = pick_stale_start();
         end
         send_item(OP_APPEND, src, pick_target(), FILE_W'($urandom), 1'b0, NO_RES);
      end else begin
         send_item(OP_LOOKUP, pick_lookup_line(), LINE_W'($urandom), FILE_W'($urandom),
                   1'b0, NO_RES);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 30) stall_left = gap_len();
      end
   end

   always @(posedge clock) begin
      result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_tdata[1:0] !== exp_res.status ||
                rsp_tdata[9:2] !== exp_res.mapped_file ||
                rsp_tdata[33:10] !== exp_res.mapped_line ||
                rsp_tdata[39:34] !== 6'd0)
               report_mismatch($sformatf(
                  "status %h/%h file %h/%h line %h/%h pad %h (got/exp)",
                  rsp_tdata[1:0], exp_res.status, rsp_tdata[9:2], exp_res.mapped_file,
                  rsp_tdata[33:10], exp_res.mapped_line, rsp_tdata[39:34]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      tbl_start[0]  = '0;
      tbl_target[0] = '0;
      tbl_file[0]   = '0;
      tbl_count     = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_rows[i].op, dir_rows[i].src, dir_rows[i].tgt, dir_rows[i].file,
                   dir_rows[i].typed, dir_rows[i].res);
      end
      wait_drained();

      // Fill the table with lookups mixed in, so searches run at every table size.
      while (tbl_count < TABLE_ENTRIES && items_sent < ITEM_TOTAL) send_random(35);
      wait_drained();

      while (items_sent < ITEM_TOTAL) send_random(20);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
